// File: rtl/btint_pkg.sv
// Package with shared types and constants for the tuple interning block.
`timescale 1ns / 1ps
package btint_pkg;

    // Default table sizes.
    localparam int DefCapacity = 4096;
    localparam int DefBuckets  = 8192;

    // Field widths of the stream beats.
    localparam int WordW   = 64;
    localparam int IndexW  = 12;
    localparam int StatusW = 2;

    // Mixing constant folded into the bucket hash.
    localparam logic [31:0] HashMix = 32'h9e3779b9;

    // Result status codes.
    typedef enum logic [StatusW-1:0] {
        ST_FOUND = 2'd0,
        ST_NEW   = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_BREAD,
        S_BCHK,
        S_ECHK,
        S_DONE
    } t_state;

endpackage

// File: rtl/btint_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module btint_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bit_exact_tuple_interning.sv
// Top level of the tuple interning block: sequencer, hash and table memories.
//
// Usage: each input beat carries a kind bit on i_s_tuser (0 = position of three
// words, 1 = weight tuple of four words) and four 64-bit key words on
// i_s_tdata. The block looks the tuple up bit for bit in the matching table and
// answers with one output beat: the dense entry index on o_m_tdata and the
// status (found, newly appended, or table full) on o_m_tuser.
// A lookup hashes the key, then probes a bucket memory and an entry memory,
// both with registered read data. From hashing the sequencer reads and checks
// the home bucket and goes to the result state when it is empty, or reads and
// checks the entry when it holds one; each bucket on the way that holds a
// different tuple repeats the bucket read, bucket check and entry check. The
// input is ready again in the cycle after the result is loaded, and one item
// is in work at a time.
// After reset the block sweeps both bucket memories, one bucket a cycle, through
// all BUCKETS buckets (8192 by default) and accepts no item meanwhile; both tables
// are empty afterwards. A result waits in the output register while the
// receiver stalls; the next item is accepted but its result is held back until
// the output register is free.
module bit_exact_tuple_interning
    import btint_pkg::*;
#(
    parameter int CAPACITY = DefCapacity,
    parameter int BUCKETS  = DefBuckets
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input beat: tdata = key_word0, key_word1, key_word2, key_word3 (low bit up).
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [255:0] i_s_tdata,
    // Input tuser: command (0 position, 1 weight tuple).
    input  logic         i_s_tuser,
    // Output beat: tdata = entry_index, then four zero pad bits.
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [15:0]  o_m_tdata,
    // Output tuser: status.
    output logic [1:0]   o_m_tuser
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int BW   = $clog2(BUCKETS);
    localparam int PW   = $clog2(BUCKETS + 1);
    localparam int PosW = 3 * WordW;
    localparam int WgtW = 4 * WordW;

    t_state r_state, n_state;

    logic [BW-1:0]      r_clr;
    logic               r_cmd;
    logic [WgtW-1:0]    r_key;
    logic [BW-1:0]      r_slot, n_slot;
    logic [PW-1:0]      r_probe, n_probe;
    logic [IW-1:0]      r_id, n_id;
    logic [CW-1:0]      r_pcnt, r_wcnt;
    logic [IW-1:0]      r_res_idx, n_res_idx;
    t_status            r_res_st, n_res_st;
    logic               r_ovalid;
    logic [IndexW-1:0]  r_oidx;
    t_status            r_ost;

    // Memory ports.
    logic               pb_we, wb_we, b_re, pe_we, we_we, e_re;
    logic [BW-1:0]      b_waddr;
    logic [CW-1:0]      b_wdata;
    logic [CW-1:0]      pb_rd, wb_rd, bkt_d;
    logic [PosW-1:0]    pe_rd;
    logic [WgtW-1:0]    we_rd;

    // Lookup helpers.
    logic [WordW-1:0]   hx;
    logic [BW-1:0]      fold;
    logic [BW-1:0]      hslot;
    logic [CW-1:0]      cnt;
    logic               tbl_full;
    logic               ent_eq;
    logic [BW-1:0]      slot_nx;
    logic [PW-1:0]      probe_nx;
    logic [CW-1:0]      bkt_m1;
    logic               do_insert;

    // Bucket hash: mix the words, fold to the bucket width, bring into range.
    always_comb begin
        hx = r_key[63:0]
           ^ {r_key[111:64], r_key[127:112]}
           ^ {r_key[159:128], r_key[191:160]}
           ^ ({64{r_cmd}} & {r_key[207:192], r_key[255:208]})
           ^ {32'd0, HashMix};
        fold = '0;
        for (int i = 0; i < WordW; i++) begin
            fold[i % BW] = fold[i % BW] ^ hx[i];
        end
        if ({1'b0, fold} >= (BW+1)'(BUCKETS)) begin
            hslot = BW'({1'b0, fold} - (BW+1)'(BUCKETS));
        end else begin
            hslot = fold;
        end
    end

    // Probe-step helpers.
    always_comb begin
        bkt_d    = r_cmd ? wb_rd : pb_rd;
        bkt_m1   = bkt_d - CW'(1);
        cnt      = r_cmd ? r_wcnt : r_pcnt;
        tbl_full = (cnt == CW'(CAPACITY));
        ent_eq   = r_cmd ? (we_rd == r_key) : (pe_rd == r_key[PosW-1:0]);
        slot_nx  = (r_slot == BW'(BUCKETS - 1)) ? '0 : r_slot + BW'(1);
        probe_nx = r_probe + PW'(1);
        do_insert = (r_state == S_BCHK) && (bkt_d == '0) && !tbl_full;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == BW'(BUCKETS - 1)) n_state = S_IDLE;
            S_IDLE:  if (i_s_tvalid) n_state = S_HASH;
            S_HASH:  n_state = S_BREAD;
            S_BREAD: n_state = S_BCHK;
            S_BCHK:  n_state = (bkt_d == '0) ? S_DONE : S_ECHK;
            S_ECHK: begin
                if (ent_eq || probe_nx == PW'(BUCKETS)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_BREAD;
                end
            end
            S_DONE:  if (!r_ovalid || i_m_tready) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // Memory controls and datapath next values.
    always_comb begin
        pb_we     = 1'b0;
        wb_we     = 1'b0;
        b_re      = 1'b0;
        pe_we     = 1'b0;
        we_we     = 1'b0;
        e_re      = 1'b0;
        b_waddr   = r_slot;
        b_wdata   = '0;
        n_slot    = r_slot;
        n_probe   = r_probe;
        n_id      = r_id;
        n_res_idx = r_res_idx;
        n_res_st  = r_res_st;
        case (r_state)
            S_CLEAR: begin
                pb_we   = 1'b1;
                wb_we   = 1'b1;
                b_waddr = r_clr;
            end
            S_HASH: begin
                n_slot  = hslot;
                n_probe = '0;
            end
            S_BREAD: b_re = 1'b1;
            S_BCHK: begin
                if (bkt_d == '0) begin
                    if (tbl_full) begin
                        n_res_idx = '0;
                        n_res_st  = ST_FULL;
                    end else begin
                        pb_we     = !r_cmd;
                        wb_we     = r_cmd;
                        pe_we     = !r_cmd;
                        we_we     = r_cmd;
                        b_wdata   = cnt + CW'(1);
                        n_res_idx = IW'(cnt);
                        n_res_st  = ST_NEW;
                    end
                end else begin
                    e_re = 1'b1;
                    n_id = IW'(bkt_m1);
                end
            end
            S_ECHK: begin
                if (ent_eq) begin
                    n_res_idx = r_id;
                    n_res_st  = ST_FOUND;
                end else begin
                    n_slot  = slot_nx;
                    n_probe = probe_nx;
                    n_res_idx = '0;
                    n_res_st  = ST_FULL;
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_pcnt   <= '0;
            r_wcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + BW'(1);
            end
            if (do_insert && !r_cmd) r_pcnt <= r_pcnt + CW'(1);
            if (do_insert && r_cmd)  r_wcnt <= r_wcnt + CW'(1);
            if (r_state == S_DONE && (!r_ovalid || i_m_tready)) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_cmd <= i_s_tuser;
            r_key <= i_s_tdata;
        end
        r_slot    <= n_slot;
        r_probe   <= n_probe;
        r_id      <= n_id;
        r_res_idx <= n_res_idx;
        r_res_st  <= n_res_st;
        if (r_state == S_DONE && (!r_ovalid || i_m_tready)) begin
            r_oidx <= IndexW'(r_res_idx);
            r_ost  <= r_res_st;
        end
    end

    // Bucket memories: entry index plus one, zero for an empty bucket.
    btint_ram #(.WIDTH(CW), .DEPTH(BUCKETS)) u_pos_bkt (
        .i_clk   (i_clk),
        .i_we    (pb_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_re    (b_re),
        .i_raddr (r_slot),
        .o_rdata (pb_rd)
    );

    btint_ram #(.WIDTH(CW), .DEPTH(BUCKETS)) u_wgt_bkt (
        .i_clk   (i_clk),
        .i_we    (wb_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_re    (b_re),
        .i_raddr (r_slot),
        .o_rdata (wb_rd)
    );

    // Entry memories: one whole tuple per row.
    btint_ram #(.WIDTH(PosW), .DEPTH(CAPACITY)) u_pos_ent (
        .i_clk   (i_clk),
        .i_we    (pe_we),
        .i_waddr (IW'(cnt)),
        .i_wdata (r_key[PosW-1:0]),
        .i_re    (e_re),
        .i_raddr (IW'(bkt_m1)),
        .o_rdata (pe_rd)
    );

    btint_ram #(.WIDTH(WgtW), .DEPTH(CAPACITY)) u_wgt_ent (
        .i_clk   (i_clk),
        .i_we    (we_we),
        .i_waddr (IW'(cnt)),
        .i_wdata (r_key),
        .i_re    (e_re),
        .i_raddr (IW'(bkt_m1)),
        .o_rdata (we_rd)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {4'd0, r_oidx};
    assign o_m_tuser  = r_ost;

endmodule
